// File: rtl/ictf_pkg.sv
// Package for the complementary tilt filter: widths, register indexes,
// arctangent table and small arithmetic helpers. No dependencies.
`default_nettype none
package ictf_pkg;

  localparam int CordicSteps = 16;
  localparam int CntW        = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_WEIGHT = 3'd0;
  localparam logic [2:0] REG_ENABLE = 3'd1;
  localparam logic [2:0] REG_AX_OFS = 3'd2;
  localparam logic [2:0] REG_AY_OFS = 3'd3;
  localparam logic [2:0] REG_AZ_OFS = 3'd4;
  localparam logic [2:0] REG_GX_OFS = 3'd5;
  localparam logic [2:0] REG_GY_OFS = 3'd6;
  localparam logic [2:0] REG_GZ_OFS = 3'd7;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [31:0] atan_q16(input logic [CntW-1:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:  v = 32'sd2949120;
      5'd1:  v = 32'sd1740967;
      5'd2:  v = 32'sd919879;
      5'd3:  v = 32'sd466945;
      5'd4:  v = 32'sd234379;
      5'd5:  v = 32'sd117304;
      5'd6:  v = 32'sd58666;
      5'd7:  v = 32'sd29335;
      5'd8:  v = 32'sd14668;
      5'd9:  v = 32'sd7334;
      5'd10: v = 32'sd3667;
      5'd11: v = 32'sd1833;
      5'd12: v = 32'sd917;
      5'd13: v = 32'sd458;
      5'd14: v = 32'sd229;
      5'd15: v = 32'sd115;
      5'd16: v = 32'sd57;
      5'd17: v = 32'sd29;
      5'd18: v = 32'sd14;
      5'd19: v = 32'sd7;
      5'd20: v = 32'sd4;
      5'd21: v = 32'sd2;
      5'd22: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/imu_complementary_tilt_filter_core.sv
// Top level of the complementary tilt filter: sequencer, square root,
// gyro integration and blend. Uses ictf_pkg and ictf_cordic.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | in_tdata 112b: ax ay az gx gy gz elapsed_ms
//  out_    | out | out_tvalid/tready  | out_tdata 96b: roll pitch yaw_step
//  cfg_    | in  | cfg_wr_en          | cfg_index 3b, cfg_data 16b
//
// A transaction runs, with out_tready high, through the square root, two CORDIC
// runs (shortened for a zero vector), the gyro steps for each axis (product,
// reciprocal multiply, remainder, reciprocal multiply), the roll and pitch
// blend, an output state and the idle state before the next acceptance.
// in_tready is high only in idle; a held result stalls the next item.
// rst_n is synchronous; clears control state, history; loads config defaults.
`default_nettype none
module imu_complementary_tilt_filter_core
  import ictf_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [111:0] in_tdata,   // ax, ay, az, gx, gy, gz, elapsed_ms
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [95:0]  out_tdata,  // roll_deg, pitch_deg, yaw_step_deg
  input  wire          cfg_wr_en,
  input  wire  [2:0]   cfg_index,
  input  wire  [15:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_PITCH, S_PWAIT, S_ROLL, S_RWAIT,
    S_MUL, S_DIV, S_BLEND, S_OUT
  } state_t;

  // Configuration
  logic [15:0]        weight_r;
  logic               enable_r;
  logic signed [15:0] ofs_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 16'd64225;
      enable_r <= 1'b1;
      for (int k = 0; k < 6; k++) ofs_r[k] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WEIGHT: weight_r <= cfg_data;
        REG_ENABLE: enable_r <= cfg_data[0];
        REG_AX_OFS: ofs_r[0] <= cfg_data;
        REG_AY_OFS: ofs_r[1] <= cfg_data;
        REG_AZ_OFS: ofs_r[2] <= cfg_data;
        REG_GX_OFS: ofs_r[3] <= cfg_data;
        REG_GY_OFS: ofs_r[4] <= cfg_data;
        REG_GZ_OFS: ofs_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t             state_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [15:0] g_r [3];
  logic [15:0]        dt_r;
  logic               have_prev_r;
  logic signed [31:0] last_roll_r, last_pitch_r;
  logic signed [31:0] acc_pitch_r, acc_roll_r;
  logic [26:0]        rem_r;      // square root remainder
  logic [47:0]        rad_r;      // radicand, shifted out two bits a step
  logic [23:0]        root_r;
  logic [CntW:0]      cnt_r;
  logic [1:0]         axis_r;
  logic [30:0]        pmag_r;     // |rate*dt|
  logic               neg_r;
  logic [21:0]        a_r;        // |rate*dt| / 1000
  logic [25:0]        v_r;        // remainder*65536 + 500
  logic signed [47:0] inc_r [3];
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic               bsel_r;

  // CORDIC operands
  logic               cstart;
  logic signed [33:0] cy, cx;
  logic               cdone;
  logic signed [31:0] cang;

  ictf_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart),
    .y_in(cy), .x_in(cx), .done(cdone), .angle(cang)
  );

  always_comb begin
    cstart = (state_r == S_PITCH) || (state_r == S_ROLL);
    if (state_r == S_PITCH) begin
      cy = 34'(ay_r) <<< 8;
      cx = 34'(az_r) <<< 8;
    end else begin
      cy = -(34'(ax_r) <<< 8);
      cx = 34'($signed({1'b0, root_r}));
    end
  end

  // Square root step: restoring, one result bit per cycle
  logic [29:0] trial;
  assign trial = {1'b0, rem_r, rad_r[47:46]} - {4'd0, root_r, 2'b01};

  // Gyro step: one product, then divide by 1000 through a shared reciprocal
  // multiply: floor(n/1000) = ((n >> 3) * ceil(2^35/125)) >> 35 for n < 2^31
  logic signed [31:0] prod;
  logic [27:0]        rin;
  logic [56:0]        rprod;
  logic [21:0]        rq;
  logic [37:0]        qsum;
  assign prod  = g_r[axis_r] * $signed({1'b0, dt_r});
  assign rin   = (cnt_r == '0) ? pmag_r[30:3] : {5'd0, v_r[25:3]};
  assign rprod = rin * 29'd274877907;
  assign rq    = rprod[56:35];
  assign qsum  = {a_r, 16'd0} + {16'd0, rq};

  // Blend for the selected axis
  logic signed [63:0] bprev, bacc, bv;
  logic signed [17:0] w18, wc18;
  assign w18   = $signed({2'b00, weight_r});
  assign wc18  = 18'sd65536 - w18;
  assign bprev = bsel_r ? 64'(last_pitch_r) + 64'(inc_r[1])
                        : 64'(last_roll_r)  + 64'(inc_r[0]);
  assign bacc  = bsel_r ? 64'(acc_pitch_r) : 64'(acc_roll_r);
  assign bv    = ((64'(w18) * bprev) + (64'(wc18) * bacc) + 64'sd32768) >>> 16;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {yaw_r, pitch_r, roll_r};

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_prev_r  <= 1'b0;
      last_roll_r  <= '0;
      last_pitch_r <= '0;
      cnt_r        <= '0;
      axis_r       <= '0;
      bsel_r       <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r   <= in_tdata[15:0]  - ofs_r[0];
            ay_r   <= in_tdata[31:16] - ofs_r[1];
            az_r   <= in_tdata[47:32] - ofs_r[2];
            g_r[0] <= in_tdata[63:48] - ofs_r[3];
            g_r[1] <= in_tdata[79:64] - ofs_r[4];
            g_r[2] <= in_tdata[95:80] - ofs_r[5];
            dt_r   <= in_tdata[111:96];
            cnt_r  <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (cnt_r == '0) begin
            // Load radicand (ay^2+az^2)*65536 and clear
            rad_r  <= {32'(ay_r * ay_r) + 32'(az_r * az_r), 16'd0};
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            if (cnt_r <= (CntW+1)'(24)) begin
              if (!trial[29]) begin
                rem_r  <= trial[26:0];
                root_r <= {root_r[22:0], 1'b1};
              end else begin
                rem_r  <= {rem_r[24:0], rad_r[47:46]};
                root_r <= {root_r[22:0], 1'b0};
              end
              rad_r <= {rad_r[45:0], 2'b00};
              cnt_r <= cnt_r + 1'b1;
            end else begin
              state_r <= S_PITCH;
            end
          end
        end
        S_PITCH: state_r <= S_PWAIT;
        S_PWAIT: if (cdone) begin
          acc_pitch_r <= cang;
          state_r     <= S_ROLL;
        end
        S_ROLL: state_r <= S_RWAIT;
        S_RWAIT: if (cdone) begin
          acc_roll_r <= cang;
          axis_r     <= '0;
          state_r    <= S_MUL;
        end
        S_MUL: begin
          neg_r   <= prod[31];
          pmag_r  <= prod[31] ? 31'(-prod) : 31'(prod);
          cnt_r   <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            // Whole thousands of |rate*dt|
            a_r   <= rq;
            cnt_r <= cnt_r + 1'b1;
          end else if (cnt_r == (CntW+1)'(1)) begin
            // Scale the remainder and add the rounding half
            v_r   <= {10'(pmag_r - 31'(a_r * 31'd1000)), 16'd0} + 26'd500;
            cnt_r <= cnt_r + 1'b1;
          end else begin
            inc_r[axis_r] <= neg_r ? -$signed(48'(qsum)) : $signed(48'(qsum));
            if (axis_r == 2'd2) begin
              bsel_r  <= 1'b0;
              state_r <= S_BLEND;
            end else begin
              axis_r  <= axis_r + 1'b1;
              state_r <= S_MUL;
            end
          end
        end
        S_BLEND: begin
          if (have_prev_r && enable_r) begin
            if (bsel_r) pitch_r <= sat32(bv);
            else        roll_r  <= sat32(bv);
          end else begin
            if (bsel_r) pitch_r <= acc_pitch_r;
            else        roll_r  <= acc_roll_r;
          end
          if (bsel_r) begin
            yaw_r   <= have_prev_r ? sat32(64'(inc_r[2])) : 32'sd0;
            state_r <= S_OUT;
          end
          bsel_r <= 1'b1;
        end
        S_OUT: if (out_tready) begin
          have_prev_r  <= 1'b1;
          last_roll_r  <= roll_r;
          last_pitch_r <= pitch_r;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid) else $error("accept during result");
  a_prev_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> have_prev_r) else $error("history not set");
  a_first_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !have_prev_r) |-> (yaw_r == 0)) else $error("first yaw nonzero");

endmodule
`default_nettype wire

// File: rtl/ictf_cordic.sv
// Iterative vectoring CORDIC returning atan2(y, x) in Q16 degrees.
// One micro-rotation per cycle; uses ictf_pkg for the angle table.
`default_nettype none
module ictf_cordic
  import ictf_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  input  wire signed [33:0]  y_in,
  input  wire signed [33:0]  x_in,
  output logic               done,
  output logic signed [31:0] angle
);

  typedef enum logic [1:0] {C_IDLE, C_RUN, C_DONE} cstate_t;

  cstate_t               state_r;
  logic signed [35:0]    x_r, y_r;
  logic signed [31:0]    z_r;
  logic [CntW-1:0]       i_r;

  logic signed [35:0] dx, dy, xw, yw;
  assign xw = 36'(x_in);
  assign yw = 36'(y_in);
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;

  assign done  = (state_r == C_DONE);
  assign angle = z_r;

  // Sequence the pre-rotation and the micro-rotations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      i_r     <= '0;
    end else begin
      unique case (state_r)
        C_IDLE: begin
          if (start) begin
            i_r <= '0;
            if (x_in == 0 && y_in == 0) begin
              x_r <= '0; y_r <= '0; z_r <= '0;
              state_r <= C_DONE;
            end else begin
              if (x_in < 0 && y_in >= 0) begin
                x_r <= yw; y_r <= -xw; z_r <= 32'sd5898240;
              end else if (x_in < 0) begin
                x_r <= -yw; y_r <= xw; z_r <= -32'sd5898240;
              end else begin
                x_r <= xw; y_r <= yw; z_r <= '0;
              end
              state_r <= C_RUN;
            end
          end
        end
        C_RUN: begin
          if (y_r >= 0) begin
            x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + atan_q16(i_r);
          end else begin
            x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - atan_q16(i_r);
          end
          i_r <= i_r + 1'b1;
          if (i_r == CntW'(CordicSteps - 1)) state_r <= C_DONE;
        end
        C_DONE: state_r <= C_IDLE;
        default: state_r <= C_IDLE;
      endcase
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("cordic done held");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == C_RUN) |-> (i_r < CntW'(CordicSteps))) else $error("cordic overrun");
  a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == C_IDLE)) else $error("cordic start while busy");

endmodule
`default_nettype wire

// File: tb/imu_complementary_tilt_filter_core_test.sv
// Testbench for imu_complementary_tilt_filter_core: drives IMU samples, predicts
// roll, pitch and yaw step in its own model, and checks every result in order.
// Depends on ictf_pkg and the core RTL.
`timescale 1ns / 1ps
module imu_complementary_tilt_filter_core_test;
  import ictf_pkg::*;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  imu_complementary_tilt_filter_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the configuration and filter state
  logic [15:0]        mdl_weight;
  logic               mdl_enable;
  logic signed [15:0] mdl_ofs [8];
  logic               mdl_primed;
  longint             mdl_roll, mdl_pitch;

  logic [95:0] tilt_queue [$];
  int          mismatches = 0;
  longint      cycles = 0;
  bit          quiet_in = 1'b0, quiet_out = 1'b0;

  function automatic longint floor_sh(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC arctangent in Q16 degrees
  function automatic longint angle_of(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_q16(i[CntW-1:0]));
      end else begin
        x -= dx; y += dy; z -= longint'(atan_q16(i[CntW-1:0]));
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(longint rate, longint dt);
    longint num, mag, q;
    num = rate * dt * 65536;
    mag = (num < 0) ? -num : num;
    q = (mag + 500) / 1000;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint mix(longint prev, longint inc, longint acc);
    longint w;
    w = longint'(mdl_weight);
    return clamp32(floor_sh(w * (prev + inc) + (65536 - w) * acc + 32768, 16));
  endfunction

  // Predict one result and advance the shadow state
  function automatic logic [95:0] predict_tilt(logic [111:0] d);
    longint ax, ay, az, g [3], dt, horiz, acc_p, acc_r, roll, pitch, yaw;
    logic signed [15:0] c;
    c = d[15:0] - mdl_ofs[REG_AX_OFS];  ax = c;
    c = d[31:16] - mdl_ofs[REG_AY_OFS]; ay = c;
    c = d[47:32] - mdl_ofs[REG_AZ_OFS]; az = c;
    c = d[63:48] - mdl_ofs[REG_GX_OFS]; g[0] = c;
    c = d[79:64] - mdl_ofs[REG_GY_OFS]; g[1] = c;
    c = d[95:80] - mdl_ofs[REG_GZ_OFS]; g[2] = c;
    dt = longint'(d[111:96]);
    horiz = root_floor((ay * ay + az * az) <<< 16);
    acc_p = angle_of(ay * 256, az * 256);
    acc_r = angle_of(-ax * 256, horiz);
    if (mdl_primed) begin
      yaw = clamp32(rate_step(g[2], dt));
      if (mdl_enable) begin
        roll = mix(mdl_roll, rate_step(g[0], dt), acc_r);
        pitch = mix(mdl_pitch, rate_step(g[1], dt), acc_p);
      end else begin
        roll = clamp32(acc_r);
        pitch = clamp32(acc_p);
      end
    end else begin
      roll = clamp32(acc_r);
      pitch = clamp32(acc_p);
      yaw = 0;
    end
    mdl_primed = 1'b1;
    mdl_roll = roll;
    mdl_pitch = pitch;
    return {yaw[31:0], pitch[31:0], roll[31:0]};
  endfunction

  // Write one register, then hold the port quiet before returning
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_WEIGHT) mdl_weight = val;
    else if (idx == REG_ENABLE) mdl_enable = val[0];
    else mdl_ofs[idx] = val;
    @(posedge clk);
  endtask

  // Send one sample, idling at random before it
  task automatic send_sample(logic [111:0] d);
    while (!quiet_in && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    tilt_queue.push_back(predict_tilt(d));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tilt_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [111:0] pack_sample(int ax, int ay, int az, int gx,
                                               int gy, int gz, int dt);
    return {dt[15:0], gz[15:0], gy[15:0], gx[15:0], az[15:0], ay[15:0], ax[15:0]};
  endfunction

  function automatic logic [111:0] rand_sample();
    return 112'({$urandom(), $urandom(), $urandom(), $urandom()});
  endfunction

  // Realistic tilt with small noise and short dt
  function automatic logic [111:0] gentle_sample();
    int s;
    s = $urandom_range(1);
    return pack_sample($urandom_range(16000) - 8000, $urandom_range(16000) - 8000,
                       s ? 16384 : -16384, $urandom_range(600) - 300,
                       $urandom_range(600) - 300, $urandom_range(600) - 300,
                       $urandom_range(50));
  endfunction

  // Directed: extremes, zero vector, left half plane, first sample
  task automatic test_directed();
    send_sample(pack_sample(0, 0, 0, 0, 0, 0, 0));
    send_sample(pack_sample(0, 0, -100, 5, 5, 5, 10));
    send_sample(pack_sample(0, 0, 0, 32767, 32767, 32767, 65535));
    send_sample(pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    send_sample(pack_sample(32767, 32767, 32767, 32767, -32768, 32767, 1));
    send_sample(pack_sample(100, -50, -200, 0, 0, 0, 20));
    send_sample(pack_sample(-100, 50, -200, -7, 7, -7, 20));
    send_sample(pack_sample(0, 1, 0, 1, 1, 1, 1));
    send_sample(pack_sample(0, -1, 0, -1, -1, -1, 1));
    send_sample(pack_sample(-32768, 0, 0, 0, 0, 0, 65535));
    send_sample(pack_sample(32767, 0, 16384, 200, -200, 0, 5));
    drain();
  endtask

  // Configuration extremes, filter off, offsets with wrap
  task automatic test_config();
    write_reg(REG_WEIGHT, 16'hffff);
    write_reg(REG_ENABLE, 16'd0);
    for (int i = 0; i < 5; i++) send_sample(gentle_sample());
    drain();
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_WEIGHT, 16'd0);
    write_reg(REG_AX_OFS, 16'h8000);
    write_reg(REG_AY_OFS, 16'h7fff);
    write_reg(REG_AZ_OFS, 16'hffff);
    write_reg(REG_GX_OFS, 16'h8000);
    write_reg(REG_GY_OFS, 16'h7fff);
    write_reg(REG_GZ_OFS, 16'h0001);
    for (int i = 0; i < 6; i++) send_sample(rand_sample());
    drain();
    write_reg(REG_WEIGHT, 16'hffff);
    for (int i = 0; i < 4; i++) send_sample(pack_sample(0, 0, 100, 32767, -32768, 5, 65535));
    drain();
  endtask

  // Random phases with varying settings
  task automatic test_random();
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_WEIGHT, (p == 0) ? 16'd64225 : 16'($urandom()));
      write_reg(REG_ENABLE, 16'(p != 3));
      for (int k = REG_AX_OFS; k <= REG_GZ_OFS; k++)
        write_reg(3'(k), (p % 2) ? 16'($urandom_range(400) - 200) : 16'($urandom()));
      quiet_in = (p == 5);
      quiet_out = (p == 5);
      for (int i = 0; i < 200; i++)
        send_sample(($urandom_range(9) < 7) ? gentle_sample() : rand_sample());
      quiet_in = 1'b0;
      quiet_out = 1'b0;
      drain();
    end
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    logic [95:0] want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      if (tilt_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = tilt_queue.pop_front();
        for (int f = 0; f < 3; f++)
          if (want[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h, got %h", f, want[f*32 +: 32],
                       out_tdata[f*32 +: 32]);
          end
      end
    end
    out_tready <= quiet_out || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("imu_complementary_tilt_filter_core_test: done, errors");
      $finish;
    end
  end

  initial begin
    mdl_weight = 16'd64225;
    mdl_enable = 1'b1;
    for (int i = 0; i < 8; i++) mdl_ofs[i] = '0;
    mdl_primed = 1'b0;
    mdl_roll = 0;
    mdl_pitch = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config();
    test_random();
    if (mismatches == 0 && tilt_queue.size() == 0) begin
      $display("imu_complementary_tilt_filter_core_test: done, clean");
    end else begin
      $display("imu_complementary_tilt_filter_core_test: done, errors");
    end
    $finish;
  end

endmodule
